// ----- hw/rtl/crc16fa_pkg.sv -----
// shared types, codes and crc function for the crc16 frame appender
package crc16fa_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        append_crc;
      logic [15:0] crc_value;
   } entry_type;

   function automatic logic [15:0] crc16fa_fold(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic [7:0]  b;
      logic        mix;
      c = crc;
      b = data;
      for (int i = 0; i < 8; i++) begin
         mix = b[0] ^ c[0];
         c = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         b = b >> 1;
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/crc16fa_front.sv -----
// front end: accepts request bytes, runs the crc, holds the append setting
module crc16fa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output crc16fa_pkg::entry_type q_entry
);
   import crc16fa_pkg::*;

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] crc_next;
   logic        append_ff;
   logic        append_in;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign crc_next   = crc16fa_fold(crc_ff, req_tdata);

   always_comb begin
      q_entry.data_byte  = req_tdata;
      q_entry.last_byte  = req_tlast;
      q_entry.append_crc = append_ff;
      q_entry.crc_value  = crc_next;
   end

   always_comb begin
      crc_in = crc_ff;
      if (q_push) begin
         crc_in = req_tlast ? 16'h0000 : crc_next;
      end
   end

   assign append_in = csr_wr_en ? csr_wr_data : append_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         append_ff <= 1'b1;
      end else begin
         crc_ff    <= crc_in;
         append_ff <= append_in;
      end
   end

endmodule

// ----- hw/rtl/crc16fa_queue.sv -----
// small register queue between front and back ends
module crc16fa_queue #(
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  crc16fa_pkg::entry_type         push_entry,
   input  logic                           pop,
   output crc16fa_pkg::entry_type         head_entry,
   output logic                           empty,
   output logic                           full,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import crc16fa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign count      = count_ff;
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/crc16fa_back.sv -----
// back end: emits payload and crc trailer bytes through an output register
module crc16fa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  crc16fa_pkg::entry_type head_entry,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);
   import crc16fa_pkg::*;

   localparam logic [1:0] PH_PAYLOAD = 2'd0;
   localparam logic [1:0] PH_CRC_LO  = 2'd1;
   localparam logic [1:0] PH_CRC_HI  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;
   logic       advance;
   logic       load;

   assign advance = !valid_ff || rsp_tready;
   assign load    = advance && !q_empty;

   always_comb begin
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         case (phase_ff)
            PH_PAYLOAD: begin
               data_in = head_entry.data_byte;
               user_in = 1'b0;
               if (head_entry.last_byte && head_entry.append_crc) begin
                  last_in  = 1'b0;
                  phase_in = PH_CRC_LO;
               end else begin
                  last_in = head_entry.last_byte;
                  q_pop   = 1'b1;
               end
            end
            PH_CRC_LO: begin
               data_in  = head_entry.crc_value[7:0];
               user_in  = 1'b1;
               last_in  = 1'b0;
               phase_in = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               data_in  = head_entry.crc_value[15:8];
               user_in  = 1'b1;
               last_in  = 1'b1;
               phase_in = PH_PAYLOAD;
               q_pop    = 1'b1;
            end
            default: begin
               valid_in = 1'b0;
               phase_in = PH_PAYLOAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PAYLOAD;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ----- hw/rtl/crc16_frame_appender_core.sv -----
// top level of the crc16 frame appender
// Payload bytes enter on req_ and leave unchanged on rsp_, one byte per clock when rsp_tready
// stays high. Each byte is folded into a CRC-16/ARC (poly 0xA001 reflected, init 0, no final
// xor) in the same cycle it is taken. With csr append set (reset value 1), the last byte of a
// frame is followed by the CRC low byte and then the high byte, flagged by rsp_tuser, so such
// a frame takes two extra output bytes; the QUEUE_DEPTH entry queue between the input side
// and the output register absorbs those bytes and any output stall, and req_tready drops
// only when it is full. The append setting in force when a frame's last byte is taken decides
// whether that frame gets its trailer. Bytes pass the queue, then the output register.
module crc16_frame_appender_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tuser,   // is_crc
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import crc16fa_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        push_entry;
   entry_type        head_entry;
   logic             q_push;
   logic             q_pop;
   logic             q_empty;
   logic             q_full;
   logic [CNT_W-1:0] q_count;

   crc16fa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   crc16fa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full),
      .count      (q_count)
   );

   crc16fa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_hi_follows_lo: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast)
      |=> (rsp_tvalid && rsp_tuser && rsp_tlast))
      else $error("crc high byte did not follow low byte");

   a_lo_holds_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser && !rsp_tlast) |-> (q_count != '0))
      else $error("frame entry left queue before crc high byte");

   a_tready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (q_count != '0))
      else $error("accepted request not queued");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// self-checking bench for the crc16 frame appender: byte stream, crc trailer and csr checks

typedef struct packed {
   logic [7:0] value;
   logic       is_crc;
   logic       last_flag;
} tx_byte_type;

class frame_crc_tracker;
   localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;

   logic [15:0] running_crc = '0;
   logic        append_on = 1'b1;
   tx_byte_type pending_bytes[$];
   int          mismatch_count = 0;

   function logic [15:0] fold_byte(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_REFLECTED_POLY) : (c >> 1);
      return c;
   endfunction

   function void note_request(logic [7:0] data, logic last);
      running_crc = fold_byte(running_crc, data);
      if (!last) begin
         pending_bytes.push_back('{data, 1'b0, 1'b0});
      end else if (!append_on) begin
         pending_bytes.push_back('{data, 1'b0, 1'b1});
         running_crc = '0;
      end else begin
         pending_bytes.push_back('{data, 1'b0, 1'b0});
         pending_bytes.push_back('{running_crc[7:0], 1'b1, 1'b0});
         pending_bytes.push_back('{running_crc[15:8], 1'b1, 1'b1});
         running_crc = '0;
      end
   endfunction

   function void note_mismatch(string what, tx_byte_type want, tx_byte_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected byte %02h crc %0b last %0b, got byte %02h crc %0b last %0b",
                  what, want.value, want.is_crc, want.last_flag,
                  got.value, got.is_crc, got.last_flag);
      end
   endfunction

   function void check_response(logic [7:0] value, logic is_crc, logic last_flag);
      tx_byte_type want;
      tx_byte_type got;
      got = '{value, is_crc, last_flag};
      if (pending_bytes.size() == 0) begin
         note_mismatch("unexpected response", '0, got);
         return;
      end
      want = pending_bytes.pop_front();
      if (got.value !== want.value || got.is_crc !== want.is_crc
          || got.last_flag !== want.last_flag) begin
         note_mismatch("response mismatch", want, got);
      end
   endfunction
endclass

module testbench;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES = 115;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic       csr_wr_data;

   frame_crc_tracker tracker = new();
   bit stalls_on = 1'b1;
   bit gaps_on = 1'b1;
   bit long_hold_req = 1'b0;
   int idle_cycles = 0;

   crc16_frame_appender_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic send_byte(input logic [7:0] data, input logic last);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_request(data, last);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input int len);
      logic [7:0] data;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 15))
            0:       data = 8'h00;
            1:       data = 8'hFF;
            default: data = 8'($urandom_range(0, 255));
         endcase
         send_byte(data, i == len - 1);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_append(input logic value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.append_on = value;
   endtask

   // response side with random stall bursts and one long hold-off on request
   initial begin : response_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            tracker.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         end
         if (hold > 0) begin
            hold--;
            if (hold == 0) begin
               rsp_tready <= 1'b1;
            end
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1)
          || (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("crc16_frame_appender_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int sent;
      int len;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte frames at the extremes, then the standard check string
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_byte(8'(8'h31 + i), i == 8);
      end
      write_append(1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h55, 1'b1);
      // append setting changed inside a frame
      send_byte(8'h55, 1'b0);
      send_byte(8'h01, 1'b0);
      write_append(1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h12, 1'b0);
      write_append(1'b0);
      send_byte(8'h34, 1'b1);
      write_append(1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: write_append(1'b0);
            2: begin
               write_append(1'b1);
               long_hold_req = 1'b1;
            end
            3: begin
               write_append(1'($urandom_range(0, 1)));
               gaps_on   = 1'b0;
               stalls_on = 1'b0;
            end
            default: ;
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_frame(len);
            sent += len;
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_bytes.size() == 0) begin
         $display("crc16_frame_appender_core: match");
      end else begin
         $display("crc16_frame_appender_core: mismatch");
      end
      $finish;
   end
endmodule

// ----- crc16_frame_appender_core.f -----
hw/rtl/crc16fa_pkg.sv
hw/rtl/crc16fa_front.sv
hw/rtl/crc16fa_queue.sv
hw/rtl/crc16fa_back.sv
hw/rtl/crc16_frame_appender_core.sv
tb/testbench.sv
